FILE: sv/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// shared types, codes and defaults of the squeeze-cycle sequencer
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int PrepareMsDef = 300;
  localparam int ReleaseMsDef = 500;
  localparam int FinishMsDef  = 1000;
  localparam int DetectRunDef = 3;

  localparam logic [8:0] OPEN_ANGLE = 9'd270;

  // phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PREPARE  = 3'd1;
  localparam logic [2:0] PH_SQUEEZE  = 3'd2;
  localparam logic [2:0] PH_HOLD     = 3'd3;
  localparam logic [2:0] PH_RELEASE  = 3'd4;
  localparam logic [2:0] PH_WAIT     = 3'd5;
  localparam logic [2:0] PH_FINISHED = 3'd6;

  // item kinds
  localparam logic [1:0] FN_TICK   = 2'd0;
  localparam logic [1:0] FN_START  = 2'd1;
  localparam logic [1:0] FN_STOP   = 2'd2;
  localparam logic [1:0] FN_SAMPLE = 2'd3;

  // register indexes
  localparam logic [2:0] REG_REACH      = 3'd0;
  localparam logic [2:0] REG_HOLD       = 3'd1;
  localparam logic [2:0] REG_STRENGTH   = 3'd2;
  localparam logic [2:0] REG_CYCLES     = 3'd3;
  localparam logic [2:0] REG_GRAD_EN    = 3'd4;
  localparam logic [2:0] REG_GRAD_FIRST = 3'd5;
  localparam logic [2:0] REG_GRAD_LAST  = 3'd6;
  localparam logic [2:0] REG_NEAR       = 3'd7;

  // operands of the serial multiply-divide: q = (a * b) / d
  typedef struct packed {
    logic [15:0] a;
    logic [7:0]  b;
    logic [15:0] d;
  } md_req_t;

endpackage

FILE: sv/servo_squeeze_cycle_sequencer.sv
// ----------------------------------------------------------------------------
// servo_squeeze_cycle_sequencer
// phase sequencer driving one servo angle through sessions of squeeze cycles
// ----------------------------------------------------------------------------
// item path: prep, then commit, which registers the result; commit waits while a result is stalled
// squeeze tick: up to two passes of the shared bit-serial multiply-divide
//   (gradation when enabled and cycle total above one, then ramp while the timer is below reach)
// one item in flight, so no new beat until the held one commits; a new beat is taken
//   while a result waits on out_stall
// reset: phase idle, timer and cycle count 0, angle 270, registers at defaults
module servo_squeeze_cycle_sequencer #(
  parameter int PREPARE_MS = ssc_pkg::PrepareMsDef,
  parameter int RELEASE_MS = ssc_pkg::ReleaseMsDef,
  parameter int FINISH_MS  = ssc_pkg::FinishMsDef,
  parameter int DETECT_RUN = ssc_pkg::DetectRunDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [13:0] distance_mm,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  angle,
  output logic [2:0]  phase,
  output logic [7:0]  cycles_done,
  output logic        session_done
);
  import ssc_pkg::*;

  localparam logic [2:0] ST_READY  = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_GRAD   = 3'd2;
  localparam logic [2:0] ST_TGT    = 3'd3;
  localparam logic [2:0] ST_TGT2   = 3'd4;
  localparam logic [2:0] ST_RAMP   = 3'd5;
  localparam logic [2:0] ST_COMMIT = 3'd6;

  // configuration
  logic [15:0] reach_ms;
  logic [15:0] hold_ms;
  logic [6:0]  strength;
  logic [7:0]  cycle_total;
  logic        grad_enable;
  logic [6:0]  grad_first;
  logic [6:0]  grad_last;
  logic [13:0] near_mm;

  // sequencer state
  logic [2:0]  phase_reg, phase_next;
  logic [15:0] phase_timer, timer_next;
  logic [7:0]  cycle_reg, cycle_next;
  logic [1:0]  detect_count, detect_next;
  logic [8:0]  angle_reg, angle_next;
  logic        done_next;

  // item and datapath
  logic [2:0]         state;
  logic [1:0]         func_q;
  logic [13:0]        dist_q;
  logic signed [16:0] s_raw;
  logic [9:0]         x9;
  logic [8:0]         ang_calc;

  logic               md_start;
  logic               md_done;
  logic [23:0]        md_q;
  md_req_t            md_req;

  logic [7:0]         diff;
  logic               diff_neg;
  logic [6:0]         diff_mag;
  logic [16:0]        q_ext;
  logic [6:0]         s_clamp;
  logic [17:0]        prod;
  logic               squeeze_tick;
  logic               commit;
  logic               grad_run;
  logic               near;
  logic [2:0]         detect_inc;

  assign pready   = 1'b1;
  assign in_stall = state != ST_READY;
  assign commit   = (state == ST_COMMIT) && (!out_valid || !out_stall);

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      reach_ms    <= 16'd500;
      hold_ms     <= 16'd500;
      strength    <= 7'd90;
      cycle_total <= 8'd3;
      grad_enable <= 1'b0;
      grad_first  <= 7'd50;
      grad_last   <= 7'd100;
      near_mm     <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_REACH:      reach_ms    <= pwdata[15:0];
        REG_HOLD:       hold_ms     <= pwdata[15:0];
        REG_STRENGTH:   strength    <= pwdata[6:0];
        REG_CYCLES:     cycle_total <= pwdata[7:0];
        REG_GRAD_EN:    grad_enable <= pwdata[0];
        REG_GRAD_FIRST: grad_first  <= pwdata[6:0];
        REG_GRAD_LAST:  grad_last   <= pwdata[6:0];
        REG_NEAR:       near_mm     <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_REACH:      prdata = {16'b0, reach_ms};
      REG_HOLD:       prdata = {16'b0, hold_ms};
      REG_STRENGTH:   prdata = {25'b0, strength};
      REG_CYCLES:     prdata = {24'b0, cycle_total};
      REG_GRAD_EN:    prdata = {31'b0, grad_enable};
      REG_GRAD_FIRST: prdata = {25'b0, grad_first};
      REG_GRAD_LAST:  prdata = {25'b0, grad_last};
      REG_NEAR:       prdata = {18'b0, near_mm};
      default:        prdata = '0;
    endcase
  end

  // target and ramp datapath
  assign squeeze_tick = (func_q == FN_TICK) && (phase_reg == PH_SQUEEZE);
  assign grad_run     = grad_enable && (cycle_total > 8'd1);
  assign diff         = {1'b0, grad_last} - {1'b0, grad_first};
  assign diff_neg     = diff[7];
  assign diff_mag     = diff_neg ? 7'(-diff) : diff[6:0];
  assign q_ext        = {2'b0, md_q[14:0]};
  assign prod         = {8'b0, x9} * 18'd205;

  always_comb begin
    if (s_raw < 0) begin
      s_clamp = '0;
    end else if (s_raw > 17'sd100) begin
      s_clamp = 7'd100;
    end else begin
      s_clamp = s_raw[6:0];
    end
  end

  always_comb begin
    md_start = 1'b0;
    md_req   = '0;
    if (state == ST_PREP && squeeze_tick && grad_run) begin
      md_start = 1'b1;
      md_req.a = {8'b0, cycle_reg};
      md_req.b = {1'b0, diff_mag};
      md_req.d = {8'b0, 8'(cycle_total - 8'd1)};
    end else if (state == ST_TGT2 && phase_timer < reach_ms) begin
      md_start = 1'b1;
      md_req.a = phase_timer;
      md_req.b = prod[17:10];
      md_req.d = reach_ms;
    end
  end

  ssc_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .req   (md_req),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_q <= func;
      dist_q <= distance_mm;
    end
    case (state)
      ST_PREP: begin
        s_raw <= grad_enable ? signed'({10'b0, grad_last}) : signed'({10'b0, strength});
      end
      ST_GRAD: begin
        if (md_done) begin
          s_raw <= signed'(17'({10'b0, grad_first} + (diff_neg ? 17'(-q_ext) : q_ext)));
        end
      end
      ST_TGT: begin
        x9 <= {s_clamp, 3'b0} + {3'b0, s_clamp};
      end
      ST_TGT2: begin
        ang_calc <= OPEN_ANGLE - {1'b0, prod[17:10]};
      end
      ST_RAMP: begin
        if (md_done) begin
          ang_calc <= OPEN_ANGLE - md_q[8:0];
        end
      end
      default: ;
    endcase
  end

  // control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
    end else begin
      case (state)
        ST_READY: begin
          if (in_valid) state <= ST_PREP;
        end
        ST_PREP: begin
          if (!squeeze_tick) begin
            state <= ST_COMMIT;
          end else if (grad_run) begin
            state <= ST_GRAD;
          end else begin
            state <= ST_TGT;
          end
        end
        ST_GRAD: begin
          if (md_done) state <= ST_TGT;
        end
        ST_TGT: begin
          state <= ST_TGT2;
        end
        ST_TGT2: begin
          state <= (phase_timer < reach_ms) ? ST_RAMP : ST_COMMIT;
        end
        ST_RAMP: begin
          if (md_done) state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (commit) state <= ST_READY;
        end
        default: state <= ST_READY;
      endcase
    end
  end

  // next architectural state for the held item
  assign near       = (near_mm != '0) && (dist_q < near_mm) && (dist_q > 14'd1);
  assign detect_inc = {1'b0, detect_count} + 3'd1;

  always_comb begin
    phase_next  = phase_reg;
    timer_next  = phase_timer;
    cycle_next  = cycle_reg;
    detect_next = detect_count;
    angle_next  = angle_reg;
    done_next   = 1'b0;
    case (func_q)
      FN_TICK: begin
        if (phase_reg != PH_IDLE && phase_reg != 3'd7) begin
          case (phase_reg)
            PH_PREPARE: begin
              angle_next = OPEN_ANGLE;
              if (phase_timer > 16'(PREPARE_MS)) phase_next = PH_SQUEEZE;
            end
            PH_SQUEEZE: begin
              angle_next = ang_calc;
              if (phase_timer >= reach_ms) phase_next = PH_HOLD;
            end
            PH_HOLD: begin
              if (phase_timer >= hold_ms) begin
                if (cycle_reg != 8'hFF) cycle_next = cycle_reg + 8'd1;
                phase_next = PH_RELEASE;
              end
            end
            PH_RELEASE: begin
              angle_next = OPEN_ANGLE;
              if (phase_timer >= 16'(RELEASE_MS)) begin
                if (cycle_reg >= cycle_total) begin
                  phase_next = PH_FINISHED;
                  done_next  = 1'b1;
                end else begin
                  phase_next = PH_WAIT;
                end
              end
            end
            PH_WAIT: begin
              phase_next = PH_SQUEEZE;
            end
            PH_FINISHED: begin
              if (phase_timer >= 16'(FINISH_MS)) begin
                phase_next = PH_IDLE;
                angle_next = OPEN_ANGLE;
              end
            end
            default: ;
          endcase
          if (phase_next != phase_reg) begin
            timer_next = '0;
          end else if (phase_timer != 16'hFFFF) begin
            timer_next = phase_timer + 16'd1;
          end
        end
      end
      FN_START: begin
        cycle_next = '0;
        phase_next = PH_PREPARE;
        timer_next = '0;
        angle_next = OPEN_ANGLE;
      end
      FN_STOP: begin
        phase_next = PH_IDLE;
        timer_next = '0;
        angle_next = OPEN_ANGLE;
      end
      FN_SAMPLE: begin
        if (phase_reg == PH_IDLE) begin
          if (near) begin
            if (detect_inc >= 3'(DETECT_RUN)) begin
              detect_next = '0;
              cycle_next  = '0;
              phase_next  = PH_PREPARE;
              timer_next  = '0;
              angle_next  = OPEN_ANGLE;
            end else begin
              detect_next = detect_inc[1:0];
            end
          end else begin
            detect_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= PH_IDLE;
      phase_timer  <= '0;
      cycle_reg    <= '0;
      detect_count <= '0;
      angle_reg    <= OPEN_ANGLE;
      out_valid    <= 1'b0;
    end else begin
      if (commit) begin
        phase_reg    <= phase_next;
        phase_timer  <= timer_next;
        cycle_reg    <= cycle_next;
        detect_count <= detect_next;
        angle_reg    <= angle_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (commit) begin
      angle        <= angle_next;
      phase        <= phase_next;
      cycles_done  <= cycle_next;
      session_done <= done_next;
    end
  end

endmodule

FILE: sv/ssc_muldiv.sv
// ----------------------------------------------------------------------------
// ssc_muldiv
// serial multiply then divide: 8 shift-add steps, then 24 restoring
// quotient steps, one bit per cycle in each operation
// ----------------------------------------------------------------------------
module ssc_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ssc_pkg::md_req_t req,
  output logic             done,
  output logic [23:0]      q
);
  import ssc_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [23:0] acc;
  logic [23:0] mcand;
  logic [7:0]  mplier;
  logic [15:0] rem;
  logic [15:0] dvsr;
  logic [16:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, acc[23]};
  assign ge     = rem_sh >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= {8'b0, req.a};
      mplier <= req.b;
      dvsr   <= req.d;
      rem    <= '0;
    end else if (busy) begin
      if (cnt[4:3] == 2'b00) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[22:0], 1'b0};
        mplier <= {1'b0, mplier[7:1]};
      end else begin
        rem <= ge ? 16'(rem_sh - {1'b0, dvsr}) : rem_sh[15:0];
        acc <= {acc[22:0], ge};
      end
    end
  end

  assign q = acc;

endmodule

FILE: sv/ssc_check.sv
// ----------------------------------------------------------------------------
// ssc_check
// port-level checks of the squeeze-cycle sequencer, bound to the top level
// ----------------------------------------------------------------------------
module ssc_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [8:0]  angle,
  input logic [2:0]  phase,
  input logic [7:0]  cycles_done,
  input logic        session_done
);
  import ssc_pkg::*;

  // an accepted input beat closes the input while it is worked on
  a_in_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input beat taken while one is in flight");

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  // end of session lands in finished
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && session_done |-> phase == PH_FINISHED)
    else $error("session_done outside finished");

  // a finished session has counted at least one cycle
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && session_done |-> cycles_done != 8'd0)
    else $error("session_done with no cycle counted");

  // servo is open outside squeeze, hold and release
  a_open_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase != PH_SQUEEZE && phase != PH_HOLD && phase != PH_RELEASE
    |-> angle == OPEN_ANGLE)
    else $error("angle not open outside squeeze, hold and release");

endmodule

bind servo_squeeze_cycle_sequencer ssc_check u_ssc_check (.*);
